### rtl/core/itbd_pkg.sv
// Shared types, constants and helpers for the integer to base digits converter.
`default_nettype none

package itbd_pkg;

    localparam int RADIX_W   = 5;
    localparam int ALPHA_W   = 64;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ALPHA_N   = 16;
    localparam int DIV_BITS  = 8;
    localparam int QUEUE_AW  = 1;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] ALPHA_HI_RESET = 64'h4645_4443_4241_3938;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MAX   = 8'd126;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX_SIZE  = 2'd0,
        REG_ALPHA_FIRST = 2'd1,
        REG_ALPHA_LAST  = 2'd2
    } t_reg_idx;

    typedef enum logic {
        K_ZERO,
        K_CONV
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
    } t_cmd_ctrl;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [ALPHA_W-1:0] alpha_lo;
        logic [ALPHA_W-1:0] alpha_hi;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_DIV,
        S_READ,
        S_EMIT
    } t_back_state;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi,
        input logic [DIGIT_W-1:0] idx
    );
        logic [ALPHA_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/itbd_if.sv
// Handshake channel interfaces for input values, output characters and register writes.
`default_nettype none

interface itbd_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itbd_out_if;
    logic                          valid;
    logic                          ready;
    logic [itbd_pkg::CHAR_W-1:0]   character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface itbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [itbd_pkg::CFG_IDX_W-1:0] index;
    logic [itbd_pkg::ALPHA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/itbd_cfg.sv
// Configuration registers and alphabet validity check.
`default_nettype none

module itbd_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    itbd_cfg_if.sink           i_cfg,
    output itbd_pkg::t_cfg     o_cfg,
    output logic               o_alpha_ok
);

    logic [itbd_pkg::RADIX_W-1:0] r_radix, n_radix;
    logic [itbd_pkg::ALPHA_W-1:0] r_alpha_lo, n_alpha_lo;
    logic [itbd_pkg::ALPHA_W-1:0] r_alpha_hi, n_alpha_hi;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_radix    = r_radix;
        n_alpha_lo = r_alpha_lo;
        n_alpha_hi = r_alpha_hi;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                itbd_pkg::REG_RADIX_SIZE:  n_radix    = i_cfg.data[itbd_pkg::RADIX_W-1:0];
                itbd_pkg::REG_ALPHA_FIRST: n_alpha_lo = i_cfg.data;
                itbd_pkg::REG_ALPHA_LAST:  n_alpha_hi = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= itbd_pkg::RADIX_RESET;
            r_alpha_lo <= itbd_pkg::ALPHA_LO_RESET;
            r_alpha_hi <= itbd_pkg::ALPHA_HI_RESET;
        end else begin
            r_radix    <= n_radix;
            r_alpha_lo <= n_alpha_lo;
            r_alpha_hi <= n_alpha_hi;
        end
    end

    // radix in 2..16; each used character printable, not a sign, unique
    always_comb begin : alpha_check
        logic [itbd_pkg::CHAR_W-1:0] ci;
        logic                        bad;
        bad = (r_radix < itbd_pkg::MIN_RADIX) || (r_radix > itbd_pkg::MAX_RADIX);
        for (int i = 0; i < itbd_pkg::ALPHA_N; i++) begin
            ci = itbd_pkg::alpha_char(r_alpha_lo, r_alpha_hi, itbd_pkg::DIGIT_W'(i));
            if (i < int'(r_radix)) begin
                if (ci == itbd_pkg::CHAR_PLUS || ci == itbd_pkg::CHAR_MINUS ||
                    ci <= itbd_pkg::CHAR_SPACE || ci > itbd_pkg::CHAR_MAX) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < itbd_pkg::ALPHA_N; j++) begin
                    if (j < int'(r_radix) &&
                        ci == itbd_pkg::alpha_char(r_alpha_lo, r_alpha_hi,
                                                   itbd_pkg::DIGIT_W'(j))) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        o_alpha_ok = !bad;
    end

    assign o_cfg.radix    = r_radix;
    assign o_cfg.alpha_lo = r_alpha_lo;
    assign o_cfg.alpha_hi = r_alpha_hi;

endmodule

`default_nettype wire

### rtl/core/itbd_front.sv
// Front end: takes input values, classifies them and forms the magnitude.
`default_nettype none

module itbd_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    itbd_in_if.sink                      i_in,
    input  wire logic                    i_alpha_ok,
    input  wire logic                    i_q_full,
    output logic                         o_push,
    output itbd_pkg::t_cmd_ctrl          o_push_ctrl,
    output logic [VALUE_WIDTH-1:0]       o_push_mag
);

    logic                   r_hold_valid, n_hold_valid;
    logic [VALUE_WIDTH-1:0] r_hold_value;
    logic                   accept;
    logic                   is_zero;
    logic                   neg;
    logic                   drop;
    logic                   done;

    assign is_zero = (r_hold_value == '0);
    assign neg     = r_hold_value[VALUE_WIDTH-1];
    // nonzero value with a bad alphabet yields no text
    assign drop    = !is_zero && !i_alpha_ok;
    assign done    = r_hold_valid && (drop || !i_q_full);
    assign accept  = i_in.valid && i_in.ready;

    assign i_in.ready       = !r_hold_valid || done;
    assign o_push           = r_hold_valid && !drop && !i_q_full;
    assign o_push_ctrl.kind = is_zero ? itbd_pkg::K_ZERO : itbd_pkg::K_CONV;
    assign o_push_ctrl.neg  = neg && !is_zero;
    assign o_push_mag       = neg ? (~r_hold_value + 1'b1) : r_hold_value;

    always_comb begin
        n_hold_valid = r_hold_valid;
        if (accept) begin
            n_hold_valid = 1'b1;
        end else if (done) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold_value <= i_in.value;
        end
    end

endmodule

`default_nettype wire

### rtl/core/itbd_fifo.sv
// Short command queue between front end and back end.
`default_nettype none

module itbd_fifo #(
    parameter int DATA_W = 34
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_valid
);

    localparam int AW    = itbd_pkg::QUEUE_AW;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = AW + 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/itbd_back.sv
// Back end: long division by the radix, digit stack and character output register.
`default_nettype none

module itbd_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_rst_n,
    input  wire logic                                                  i_q_valid,
    input  wire logic [$bits(itbd_pkg::t_cmd_ctrl)+VALUE_WIDTH-1:0]    i_q_data,
    output logic                                                       o_q_pop,
    input  wire itbd_pkg::t_cfg                                        i_cfg,
    itbd_out_if.source                                                 o_out
);

    localparam int NCH = (VALUE_WIDTH + itbd_pkg::DIV_BITS - 1) / itbd_pkg::DIV_BITS;
    localparam int PW  = NCH * itbd_pkg::DIV_BITS;
    localparam int CW  = $clog2(VALUE_WIDTH + 1);
    localparam int IW  = $clog2(VALUE_WIDTH);
    localparam int KW  = $clog2(NCH + 1);
    localparam int DW  = $bits(itbd_pkg::t_cmd_ctrl) + VALUE_WIDTH;

    itbd_pkg::t_cmd_ctrl           q_ctrl;
    logic [VALUE_WIDTH-1:0]        q_mag;
    itbd_pkg::t_back_state         r_state, n_state;
    logic [PW-1:0]                 r_work, n_work, div_work;
    logic [itbd_pkg::DIGIT_W-1:0]  r_rem, n_rem, div_rem;
    logic [KW-1:0]                 r_chunk, n_chunk;
    logic [CW-1:0]                 r_cnt, n_cnt, cnt_dec;
    logic                          r_ovalid, n_ovalid;
    logic [itbd_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                          r_last, n_last;
    logic [itbd_pkg::DIGIT_W-1:0]  r_stack [VALUE_WIDTH];
    logic [itbd_pkg::DIGIT_W-1:0]  r_rd;
    logic                          mem_we;
    logic                          mem_re;
    logic                          can_load;

    assign q_ctrl   = i_q_data[DW-1:VALUE_WIDTH];
    assign q_mag    = i_q_data[VALUE_WIDTH-1:0];
    assign cnt_dec  = r_cnt - 1'b1;
    assign can_load = !r_ovalid || o_out.ready;

    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    // one chunk of restoring division: quotient bits shift in at the bottom
    always_comb begin : div_step
        logic [itbd_pkg::DIGIT_W:0]   rem5;
        logic [itbd_pkg::DIGIT_W-1:0] rem;
        logic [PW-1:0]                work;
        rem  = r_rem;
        work = r_work;
        rem5 = '0;
        for (int k = 0; k < itbd_pkg::DIV_BITS; k++) begin
            rem5 = {rem, work[PW-1]};
            work = {work[PW-2:0], 1'b0};
            if (rem5 >= i_cfg.radix) begin
                rem5    = rem5 - i_cfg.radix;
                work[0] = 1'b1;
            end
            rem = rem5[itbd_pkg::DIGIT_W-1:0];
        end
        div_rem  = rem;
        div_work = work;
    end

    always_comb begin
        n_state  = r_state;
        n_work   = r_work;
        n_rem    = r_rem;
        n_chunk  = r_chunk;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !o_out.ready;
        n_char   = r_char;
        n_last   = r_last;
        o_q_pop  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        case (r_state)
            itbd_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (q_ctrl.kind == itbd_pkg::K_ZERO) begin
                        if (can_load) begin
                            o_q_pop  = 1'b1;
                            n_ovalid = 1'b1;
                            n_char   = itbd_pkg::alpha_char(i_cfg.alpha_lo, i_cfg.alpha_hi,
                                                            '0);
                            n_last   = 1'b1;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        n_work  = PW'(q_mag);
                        n_rem   = '0;
                        n_chunk = '0;
                        n_cnt   = '0;
                        n_state = q_ctrl.neg ? itbd_pkg::S_SIGN : itbd_pkg::S_DIV;
                    end
                end
            end
            itbd_pkg::S_SIGN: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_char   = itbd_pkg::CHAR_MINUS;
                    n_last   = 1'b0;
                    n_state  = itbd_pkg::S_DIV;
                end
            end
            itbd_pkg::S_DIV: begin
                n_work  = div_work;
                n_rem   = div_rem;
                n_chunk = r_chunk + 1'b1;
                if (r_chunk == KW'(NCH - 1)) begin
                    // digit complete: push it, stop once the quotient is zero
                    mem_we  = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    if (div_work == '0) begin
                        n_state = itbd_pkg::S_READ;
                    end
                end
            end
            itbd_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_cnt   = cnt_dec;
                n_state = itbd_pkg::S_EMIT;
            end
            itbd_pkg::S_EMIT: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_char   = itbd_pkg::alpha_char(i_cfg.alpha_lo, i_cfg.alpha_hi, r_rd);
                    n_last   = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = itbd_pkg::S_IDLE;
                    end else begin
                        // fetch the next digit down while this one goes out
                        mem_re = 1'b1;
                        n_cnt  = cnt_dec;
                    end
                end
            end
            default: n_state = itbd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itbd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_chunk  <= '0;
            r_cnt    <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_chunk  <= n_chunk;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[r_cnt[IW-1:0]] <= div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= r_stack[cnt_dec[IW-1:0]];
        end
    end

endmodule

`default_nettype wire

### rtl/core/integer_to_base_digits.sv
// Integer to base digits converter: top level.
//
// Converts signed VALUE_WIDTH-bit values to text in a programmable radix
// (2 to 16) with a programmable 16-character alphabet, one character per
// transfer on o_out, most significant first, a leading '-' for negative
// values, and last set on the final character of each value.
// i_in takes one value per transfer; i_cfg writes register 0 (radix size),
// 1 (characters 0..7) or 2 (characters 8..15), always ready.
// A value is registered in the front end, classified from that register
// and queued. The back end runs restoring long division, 8 bits per
// cycle, each digit dividing the whole magnitude in 8-bit chunks. It pops a
// nonzero value, emits a '-' for a negative one, divides digit by digit onto
// the stack, reads the first digit back and emits the digits; a zero is
// popped and emitted as character 0 of the alphabet. A nonzero value
// with a bad alphabet yields no output.
// Reset restores radix 10 and the alphabet "0123456789ABCDEF", empties
// the queue and drops any value in flight.
// When the receiver stalls, the output register holds its character; the
// back end keeps dividing once any sign is out and waits only to emit, while
// the two-entry queue and the front register keep taking up to three more values.
`default_nettype none

module integer_to_base_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itbd_in_if.sink     i_in,
    itbd_out_if.source  o_out,
    itbd_cfg_if.sink    i_cfg
);

    localparam int DW = $bits(itbd_pkg::t_cmd_ctrl) + VALUE_WIDTH;

    itbd_pkg::t_cfg         cfg_bus;
    logic                   alpha_ok;
    logic                   q_push;
    itbd_pkg::t_cmd_ctrl    push_ctrl;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    logic [DW-1:0]          q_data;

    itbd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .o_cfg      (cfg_bus),
        .o_alpha_ok (alpha_ok)
    );

    itbd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_alpha_ok  (alpha_ok),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_ctrl (push_ctrl),
        .o_push_mag  (push_mag)
    );

    itbd_fifo #(
        .DATA_W (DW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({push_ctrl, push_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid)
    );

    itbd_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_cfg     (cfg_bus),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_conv_needs_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && push_ctrl.kind == itbd_pkg::K_CONV) |-> alpha_ok)
        else $error("conversion queued with an invalid alphabet");

    a_conv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && push_ctrl.kind == itbd_pkg::K_CONV) |-> (push_mag != '0))
        else $error("conversion queued with zero magnitude");
`endif

endmodule

`default_nettype wire
